// File: hw/rtl/rls_instantaneous_frequency_core_assert.svh
// Assertion macros for the instantaneous frequency core.
// Each macro expects clk and arst_n in scope.
`ifndef RLS_INSTANTANEOUS_FREQUENCY_CORE_ASSERT_SVH
`define RLS_INSTANTANEOUS_FREQUENCY_CORE_ASSERT_SVH

// Condition must never hold.
`define RIF_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("rif: forbidden condition seen");

// Antecedent implies consequent in the following cycle.
`define RIF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rif: next-cycle check failed");

`endif

// File: hw/rtl/rif_pkg.sv
package rif_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 41;
	localparam int GAIN_W   = 38;
	localparam int FF_W     = 17;
	localparam int FREQ_W   = 15;
	localparam int CORDIC_STEPS = 20;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = 2;

	typedef enum logic [0:0] {
		ITEM_LOAD   = 1'b0,
		ITEM_UPDATE = 1'b1
	} item_kind_t;

	// Work item handed from the front to the update engine
	typedef struct packed {
		item_kind_t                  kind;
		logic signed [SAMPLE_W-1:0]  y_re;
		logic signed [SAMPLE_W-1:0]  y_im;
		logic signed [SAMPLE_W-1:0]  x_re;
		logic signed [SAMPLE_W-1:0]  x_im;
	} q_entry_t;

	// Updated coefficient handed to the angle unit
	typedef struct packed {
		logic signed [COEF_W-1:0] coeff_re;
		logic signed [COEF_W-1:0] coeff_im;
		logic                     saturated;
	} coeff_req_t;

	// Arctangent of 2^-k in units of 2^-24 turn
	function automatic logic [21:0] atan_unit(input logic [4:0] k);
		logic [21:0] v;
		case (k)
			5'd0:  v = 22'd2097152;
			5'd1:  v = 22'd1238021;
			5'd2:  v = 22'd654136;
			5'd3:  v = 22'd332050;
			5'd4:  v = 22'd166669;
			5'd5:  v = 22'd83416;
			5'd6:  v = 22'd41718;
			5'd7:  v = 22'd20860;
			5'd8:  v = 22'd10430;
			5'd9:  v = 22'd5215;
			5'd10: v = 22'd2608;
			5'd11: v = 22'd1304;
			5'd12: v = 22'd652;
			5'd13: v = 22'd326;
			5'd14: v = 22'd163;
			5'd15: v = 22'd81;
			5'd16: v = 22'd41;
			5'd17: v = 22'd20;
			5'd18: v = 22'd10;
			5'd19: v = 22'd5;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/rif_front.sv
module rif_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // [15:0] sample_re, [31:16] sample_im
	input  logic              s_tuser,   // [0] first
	input  logic              q_full,
	output logic              q_push,
	output rif_pkg::q_entry_t q_data
);
	import rif_pkg::*;

	typedef enum logic [2:0] {
		PH_NONE   = 3'b001,
		PH_LOADED = 3'b010,
		PH_HELD   = 3'b100
	} phase_t;

	phase_t                     phase_q;
	logic signed [SAMPLE_W-1:0] prev_re_q;
	logic signed [SAMPLE_W-1:0] prev_im_q;
	logic                       accept;
	logic                       restart;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tuser || (phase_q == PH_NONE);

	// Classify the request: restart loads, held sample updates
	always_comb begin
		q_data.kind = restart ? ITEM_LOAD : ITEM_UPDATE;
		q_data.y_re = $signed(s_tdata[15:0]);
		q_data.y_im = $signed(s_tdata[31:16]);
		q_data.x_re = prev_re_q;
		q_data.x_im = prev_im_q;
		q_push      = accept && (restart || (phase_q == PH_HELD));
	end

	// Advance the signal phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NONE;
		end else if (accept) begin
			phase_q <= restart ? PH_LOADED : PH_HELD;
		end
	end

	// Hold the last sample as predictor input
	always_ff @(posedge clk) begin
		if (accept && !restart) begin
			prev_re_q <= $signed(s_tdata[15:0]);
			prev_im_q <= $signed(s_tdata[31:16]);
		end
	end

endmodule

// File: hw/rtl/rif_queue.sv
module rif_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rif_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output rif_pkg::q_entry_t pop_data,
	output logic              empty
);
	import rif_pkg::*;

	q_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

// File: hw/rtl/rif_update.sv
module rif_update (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rif_pkg::FF_W-1:0] cfg_data,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  rif_pkg::q_entry_t        q_data,
	output logic                     c_valid,
	input  logic                     c_ready,
	output rif_pkg::coeff_req_t      c_req
);
	import rif_pkg::*;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'h40000000);
	localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	// Multiplier step codes
	localparam logic [4:0] ST_XRR    = 5'd0;
	localparam logic [4:0] ST_XII    = 5'd1;
	localparam logic [4:0] ST_CRXR   = 5'd2;
	localparam logic [4:0] ST_CIXI   = 5'd3;
	localparam logic [4:0] ST_CRXI   = 5'd4;
	localparam logic [4:0] ST_CIXR   = 5'd5;
	localparam logic [4:0] ST_GS     = 5'd6;
	localparam logic [4:0] ST_GXR    = 5'd7;
	localparam logic [4:0] ST_GXI    = 5'd8;
	localparam logic [4:0] ST_PRE_H  = 5'd9;
	localparam logic [4:0] ST_PRE_L  = 5'd10;
	localparam logic [4:0] ST_PIE_H  = 5'd11;
	localparam logic [4:0] ST_PIE_L  = 5'd12;
	localparam logic [4:0] ST_PREI_H = 5'd13;
	localparam logic [4:0] ST_PREI_L = 5'd14;
	localparam logic [4:0] ST_PIER_H = 5'd15;
	localparam logic [4:0] ST_PIER_L = 5'd16;

	typedef enum logic [8:0] {
		U_IDLE = 9'b000000001,
		U_MULA = 9'b000000010,
		U_DEN  = 9'b000000100,
		U_DIVS = 9'b000001000,
		U_DIV  = 9'b000010000,
		U_MULB = 9'b000100000,
		U_FIN  = 9'b001000000,
		U_UPD  = 9'b010000000,
		U_HAND = 9'b100000000
	} ustate_t;

	ustate_t                    state_q;
	logic [4:0]                 step_q;
	logic [5:0]                 dcnt_q;
	logic [FF_W-1:0]            alpha_q;
	logic signed [COEF_W-1:0]   coeff_re_q;
	logic signed [COEF_W-1:0]   coeff_im_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       sat_q;

	logic signed [SAMPLE_W-1:0] x_re_q, x_im_q, y_re_q, y_im_q;
	logic                       pvalid_s1;
	logic [4:0]                 pstep_s1;
	logic signed [60:0]         prod_s1;
	logic [31:0]                s_q;
	logic signed [57:0]         er_q, ei_q;
	logic [56:0]                den_q;
	logic signed [29:0]         ps_re_q, ps_im_q;
	logic signed [63:0]         acc_re_q, acc_im_q;
	logic [56:0]                rem_q;
	logic [GAIN_W-1:0]          quo_q;

	logic signed [41:0]         a_op;
	logic signed [18:0]         b_op;
	logic signed [32:0]         e_re, e_im;
	logic signed [18:0]         erh_b, erl_b, eih_b, eil_b;
	logic                       issue;
	logic [56:0]                gain_sh;
	logic [56:0]                rem2;
	logic                       rem_ge;
	logic [56:0]                rem_next;
	logic [GAIN_W-1:0]          quo_next;
	logic signed [55:0]         nre, nim;
	logic [COEF_W:0]            clip_re, clip_im;

	// Clip to the coefficient range; top bit flags a clip
	function automatic logic [COEF_W:0] clip_coef(input logic signed [55:0] v);
		logic [COEF_W:0] r;
		if (v[55:COEF_W-1] == {(57-COEF_W){v[COEF_W-1]}}) begin
			r = {1'b0, v[COEF_W-1:0]};
		end else begin
			r = {1'b1, (v[55] ? COEF_MIN : COEF_MAX)};
		end
		return r;
	endfunction

	assign e_re  = $signed(er_q[57:25]);
	assign e_im  = $signed(ei_q[57:25]);
	assign erh_b = 19'($signed(e_re[32:16]));
	assign erl_b = $signed({3'b000, e_re[15:0]});
	assign eih_b = 19'($signed(e_im[32:16]));
	assign eil_b = $signed({3'b000, e_im[15:0]});
	assign issue = (state_q == U_MULA) || (state_q == U_MULB);
	assign q_pop = (state_q == U_IDLE) && !q_empty;

	// Select multiplier operands for the current step
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (step_q)
			ST_XRR:    begin a_op = 42'(x_re_q);     b_op = 19'(x_re_q); end
			ST_XII:    begin a_op = 42'(x_im_q);     b_op = 19'(x_im_q); end
			ST_CRXR:   begin a_op = 42'(coeff_re_q); b_op = 19'(x_re_q); end
			ST_CIXI:   begin a_op = 42'(coeff_im_q); b_op = 19'(x_im_q); end
			ST_CRXI:   begin a_op = 42'(coeff_re_q); b_op = 19'(x_im_q); end
			ST_CIXR:   begin a_op = 42'(coeff_im_q); b_op = 19'(x_re_q); end
			ST_GS:     begin
				a_op = $signed({4'b0000, gain_q});
				b_op = $signed({1'b0, s_q[31:14]});
			end
			ST_GXR:    begin a_op = $signed({4'b0000, gain_q}); b_op = 19'(x_re_q); end
			ST_GXI:    begin a_op = $signed({4'b0000, gain_q}); b_op = 19'(x_im_q); end
			ST_PRE_H:  begin a_op = 42'(ps_re_q); b_op = erh_b; end
			ST_PRE_L:  begin a_op = 42'(ps_re_q); b_op = erl_b; end
			ST_PIE_H:  begin a_op = 42'(ps_im_q); b_op = eih_b; end
			ST_PIE_L:  begin a_op = 42'(ps_im_q); b_op = eil_b; end
			ST_PREI_H: begin a_op = 42'(ps_re_q); b_op = eih_b; end
			ST_PREI_L: begin a_op = 42'(ps_re_q); b_op = eil_b; end
			ST_PIER_H: begin a_op = 42'(ps_im_q); b_op = erh_b; end
			ST_PIER_L: begin a_op = 42'(ps_im_q); b_op = erl_b; end
			default:   begin a_op = '0; b_op = '0; end
		endcase
	end

	// One restoring divider step
	always_comb begin
		gain_sh  = {11'b0, gain_q, 8'b0};
		rem2     = {rem_q[55:0], 1'b0};
		rem_ge   = (rem2 >= den_q);
		rem_next = rem_ge ? (rem2 - den_q) : rem2;
		quo_next = {quo_q[GAIN_W-2:0], rem_ge};
	end

	// New coefficient after correction
	always_comb begin
		nre     = 56'(coeff_re_q) - 56'($signed(acc_re_q[63:10]));
		nim     = 56'(coeff_im_q) - 56'($signed(acc_im_q[63:10]));
		clip_re = clip_coef(nre);
		clip_im = clip_coef(nim);
	end

	assign c_valid        = (state_q == U_HAND);
	assign c_req.coeff_re = coeff_re_q;
	assign c_req.coeff_im = coeff_im_q;
	assign c_req.saturated = sat_q;

	// Sequence one update: products, gain division, correction; a load item only sets the coefficient and resets the gain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= U_IDLE;
			step_q     <= ST_XRR;
			dcnt_q     <= '0;
			pvalid_s1  <= 1'b0;
			alpha_q    <= FF_W'(65536);
			coeff_re_q <= '0;
			coeff_im_q <= '0;
			gain_q     <= GAIN_ONE;
			sat_q      <= 1'b0;
		end else begin
			pvalid_s1 <= issue;
			if (cfg_we) alpha_q <= cfg_data;
			case (state_q)
				U_IDLE: begin
					if (!q_empty) begin
						if (q_data.kind == ITEM_LOAD) begin
							coeff_re_q <= 41'(q_data.y_re) <<< 15;
							coeff_im_q <= 41'(q_data.y_im) <<< 15;
							gain_q     <= GAIN_ONE;
						end else begin
							sat_q   <= 1'b0;
							step_q  <= ST_XRR;
							state_q <= U_MULA;
						end
					end
				end
				U_MULA: begin
					if (step_q == ST_GS) state_q <= U_DEN;
					else step_q <= step_q + 1'b1;
				end
				U_DEN: state_q <= U_DIVS;
				U_DIVS: begin
					if (gain_sh >= den_q) begin
						gain_q  <= GAIN_MAX;
						sat_q   <= 1'b1;
						step_q  <= ST_GXR;
						state_q <= U_MULB;
					end else begin
						dcnt_q  <= '0;
						state_q <= U_DIV;
					end
				end
				U_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == 6'(GAIN_W - 1)) begin
						gain_q  <= quo_next;
						step_q  <= ST_GXR;
						state_q <= U_MULB;
					end
				end
				U_MULB: begin
					if (step_q == ST_PIER_L) state_q <= U_FIN;
					else step_q <= step_q + 1'b1;
				end
				U_FIN: state_q <= U_UPD;
				U_UPD: begin
					coeff_re_q <= $signed(clip_re[COEF_W-1:0]);
					coeff_im_q <= $signed(clip_im[COEF_W-1:0]);
					sat_q      <= sat_q | clip_re[COEF_W] | clip_im[COEF_W];
					state_q    <= U_HAND;
				end
				U_HAND: begin
					if (c_ready) state_q <= U_IDLE;
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	// Datapath registers: multiply, then fold the product in
	always_ff @(posedge clk) begin
		prod_s1  <= a_op * b_op;
		pstep_s1 <= step_q;
		if (q_pop) begin
			x_re_q <= q_data.x_re;
			x_im_q <= q_data.x_im;
			y_re_q <= q_data.y_re;
			y_im_q <= q_data.y_im;
		end
		if (state_q == U_DIVS) begin
			rem_q <= gain_sh;
			quo_q <= '0;
		end else if (state_q == U_DIV) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (pvalid_s1) begin
			case (pstep_s1)
				ST_XRR:    s_q <= prod_s1[31:0];
				ST_XII:    s_q <= s_q + prod_s1[31:0];
				ST_CRXR:   er_q <= $signed(prod_s1[57:0]) + (58'(y_re_q) <<< 30);
				ST_CIXI:   er_q <= er_q - $signed(prod_s1[57:0]);
				ST_CRXI:   ei_q <= $signed(prod_s1[57:0]) + (58'(y_im_q) <<< 30);
				ST_CIXR:   ei_q <= ei_q + $signed(prod_s1[57:0]);
				ST_GS:     den_q <= {10'b0, alpha_q, 30'b0} + prod_s1[56:0];
				ST_GXR:    ps_re_q <= $signed(prod_s1[54:25]);
				ST_GXI:    ps_im_q <= $signed(prod_s1[54:25]);
				ST_PRE_H:  acc_re_q <= 64'(prod_s1) <<< 16;
				ST_PRE_L:  acc_re_q <= acc_re_q + 64'(prod_s1);
				ST_PIE_H:  acc_re_q <= acc_re_q + (64'(prod_s1) <<< 16);
				ST_PIE_L:  acc_re_q <= acc_re_q + 64'(prod_s1);
				ST_PREI_H: acc_im_q <= 64'(prod_s1) <<< 16;
				ST_PREI_L: acc_im_q <= acc_im_q + 64'(prod_s1);
				ST_PIER_H: acc_im_q <= acc_im_q - (64'(prod_s1) <<< 16);
				ST_PIER_L: acc_im_q <= acc_im_q - 64'(prod_s1);
				default:   s_q <= s_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/rif_cordic.sv
module rif_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                c_valid,
	output logic                c_ready,
	input  rif_pkg::coeff_req_t c_req,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // [14:0] frequency, [15] zero
	output logic                m_tuser    // [0] saturated
);
	import rif_pkg::*;

	localparam logic [FREQ_W-1:0] FREQ_QUARTER = FREQ_W'(16384);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_DONE = 3'b100
	} cstate_t;

	cstate_t            state_q;
	logic [4:0]         k_q;
	logic signed [43:0] xv_q, yv_q;
	logic signed [24:0] z_q;
	logic [FREQ_W-1:0]  res_q;
	logic               res_sat_q;
	logic               out_valid_q;
	logic [FREQ_W-1:0]  out_freq_q;
	logic               out_sat_q;

	logic signed [43:0] xn, yn;
	logic signed [24:0] zn, ang;
	logic               out_load;

	assign c_ready  = (state_q == C_IDLE);
	assign out_load = (state_q == C_DONE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_freq_q};
	assign m_tuser  = out_sat_q;

	// Rotate toward the real axis by one micro-angle
	always_comb begin
		ang = $signed({3'b000, atan_unit(k_q)});
		if (!yv_q[43]) begin
			xn = xv_q + (yv_q >>> k_q);
			yn = yv_q - (xv_q >>> k_q);
			zn = z_q + ang;
		end else begin
			xn = xv_q - (yv_q >>> k_q);
			yn = yv_q + (xv_q >>> k_q);
			zn = z_q - ang;
		end
	end

	// Iterate the vectoring loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (c_valid) begin
						k_q     <= '0;
						state_q <= (c_req.coeff_re == '0) ? C_DONE : C_RUN;
					end
				end
				C_RUN: begin
					if (k_q == 5'(CORDIC_STEPS - 1)) state_q <= C_DONE;
					else k_q <= k_q + 1'b1;
				end
				C_DONE: begin
					if (out_load) state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (c_ready && c_valid) begin
			res_sat_q <= c_req.saturated;
			z_q       <= '0;
			if (c_req.coeff_re == '0) begin
				res_q <= (c_req.coeff_im != '0) ? FREQ_QUARTER : '0;
			end
			if (c_req.coeff_re[COEF_W-1]) begin
				xv_q <= -44'(c_req.coeff_re);
				yv_q <= -44'(c_req.coeff_im);
			end else begin
				xv_q <= 44'(c_req.coeff_re);
				yv_q <= 44'(c_req.coeff_im);
			end
		end else if (state_q == C_RUN) begin
			xv_q <= xn;
			yv_q <= yn;
			z_q  <= zn;
			if (k_q == 5'(CORDIC_STEPS - 1)) res_q <= zn[22:8];
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_freq_q <= res_q;
			out_sat_q  <= res_sat_q;
		end
	end

endmodule

// File: hw/rtl/rls_instantaneous_frequency_core.sv
// Path: an updating sample passes through the queue, the update engine and the angle unit
// before its result appears; saturated-gain steps skip the gain division.
// Pacing: the update engine works on one updating sample at a time, set by the 38-step gain
// divider and the shared multiplier; the angle unit overlaps the next update.
// Reset (arst_n low, asynchronous): no signal, zero coefficient, gain 1.0,
// forgetting factor 1.0, queue and output empty.
`include "rls_instantaneous_frequency_core_assert.svh"

module rls_instantaneous_frequency_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rif_pkg::FF_W-1:0] cfg_data,   // forgetting_factor
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [31:0]              s_tdata,    // [15:0] sample_re, [31:16] sample_im
	input  logic                     s_tuser,    // [0] first
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [15:0]              m_tdata,    // [14:0] frequency, [15] zero
	output logic                     m_tuser     // [0] saturated
);
	import rif_pkg::*;

	logic       q_push, q_full, q_pop, q_empty;
	q_entry_t   q_wr, q_rd;
	logic       c_valid, c_ready;
	coeff_req_t c_req;

	rif_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wr)
	);

	rif_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wr),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_rd),
		.empty     (q_empty)
	);

	rif_update u_update (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_data   (q_rd),
		.c_valid  (c_valid),
		.c_ready  (c_ready),
		.c_req    (c_req)
	);

	rif_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.c_valid  (c_valid),
		.c_ready  (c_ready),
		.c_req    (c_req),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Queue never overruns or underruns; angle unit goes busy on a request
	`RIF_ASSERT_NEVER(a_queue_overflow, q_push && q_full)
	`RIF_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty)
	`RIF_ASSERT_NEXT(a_cordic_busy, c_valid && c_ready, !c_ready)

endmodule

// File: tb/rls_instantaneous_frequency_core_tb.sv
module rls_instantaneous_frequency_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint GAIN_ONE = 64'd1 << 30;
	localparam longint GAIN_MAX = (64'd1 << 38) - 1;
	localparam longint COEF_MAX = (64'sd1 <<< 40) - 1;
	localparam longint COEF_MIN = -(64'sd1 <<< 40);
	localparam int IDLE_PCT = 37;
	localparam int SETTLE_CYCLES = 200;
	localparam int NUM_PHASES = 7;

	typedef struct {
		logic [15:0] re;
		logic [15:0] im;
		logic        first;
	} sample_t;

	typedef struct {
		logic [14:0] freq;
		logic        sat;
	} freq_result_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [rif_pkg::FF_W-1:0] cfg_data;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [31:0]              s_tdata;   // [15:0] sample_re, [31:16] sample_im
	logic                     s_tuser;   // [0] first
	logic                     m_tvalid;
	logic                     m_tready;
	logic [15:0]              m_tdata;   // [14:0] frequency, [15] zero
	logic                     m_tuser;   // [0] saturated

	sample_t      pending_samples[$];
	freq_result_t expected_freqs[$];
	int           mismatches;
	bit           calm;

	// estimator state mirrored by the predictor
	longint est_c_re, est_c_im, est_gain, est_x_re, est_x_im;
	int     est_phase;
	longint unsigned est_alpha;

	longint atan_lut[20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
		20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

	rls_instantaneous_frequency_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// vectoring CORDIC, angle modulo half a turn in 2^-16 turn units
	function automatic logic [14:0] coeff_angle(input longint re, input longint im);
		longint xv, yv, z, nx, ny;
		z = 0;
		if (re == 0)
			return (im == 0) ? 15'd0 : 15'd16384;
		if (re < 0) begin
			re = -re;
			im = -im;
		end
		xv = re;
		yv = im;
		for (int k = 0; k < 20; k++) begin
			if (yv >= 0) begin
				nx = xv + (yv >>> k);
				ny = yv - (xv >>> k);
				z += atan_lut[k];
			end else begin
				nx = xv - (yv >>> k);
				ny = yv + (xv >>> k);
				z -= atan_lut[k];
			end
			xv = nx;
			yv = ny;
		end
		return 15'((z & 64'h7FFFFF) >> 8);
	endfunction

	// advance the estimator by one accepted sample
	task automatic predict_frequency(input logic [15:0] re, input logic [15:0] im,
			input logic first);
		longint yr, yi, er, ei, ps_re, ps_im, cor_re, cor_im, nc_re, nc_im;
		longint unsigned s16, den, q, r;
		bit sat;
		freq_result_t res;
		yr = longint'($signed(re));
		yi = longint'($signed(im));
		sat = 1'b0;
		if (first || est_phase == 0) begin
			est_c_re = yr * 32768;
			est_c_im = yi * 32768;
			est_gain = GAIN_ONE;
			est_phase = 1;
		end else if (est_phase != 2) begin
			est_x_re = yr;
			est_x_im = yi;
			est_phase = 2;
		end else begin
			er = ((est_c_re * est_x_re - est_c_im * est_x_im) >>> 15) + yr * 32768;
			ei = ((est_c_re * est_x_im + est_c_im * est_x_re) >>> 15) + yi * 32768;
			s16 = longint'(est_x_re * est_x_re + est_x_im * est_x_im) >> 14;
			den = (est_alpha << 30) + longint'(est_gain) * s16;
			if (den == 0) begin
				est_gain = GAIN_MAX;
				sat = 1'b1;
			end else begin
				q = longint'(est_gain) / den;
				r = longint'(est_gain) % den;
				for (int k = 0; k < 46; k++) begin
					if (q > GAIN_MAX)
						break;
					q = q << 1;
					r = r << 1;
					if (r >= den) begin
						r -= den;
						q |= 1;
					end
				end
				if (q > GAIN_MAX) begin
					sat = 1'b1;
					q = GAIN_MAX;
				end
				est_gain = longint'(q);
			end
			ps_re = (est_gain * est_x_re) >>> 25;
			ps_im = (est_gain * est_x_im) >>> 25;
			er = er >>> 10;
			ei = ei >>> 10;
			cor_re = (ps_re * er + ps_im * ei) >>> 10;
			cor_im = (ps_re * ei - ps_im * er) >>> 10;
			nc_re = est_c_re - cor_re;
			nc_im = est_c_im - cor_im;
			if (nc_re > COEF_MAX) begin nc_re = COEF_MAX; sat = 1'b1; end
			if (nc_re < COEF_MIN) begin nc_re = COEF_MIN; sat = 1'b1; end
			if (nc_im > COEF_MAX) begin nc_im = COEF_MAX; sat = 1'b1; end
			if (nc_im < COEF_MIN) begin nc_im = COEF_MIN; sat = 1'b1; end
			est_c_re = nc_re;
			est_c_im = nc_im;
			est_x_re = yr;
			est_x_im = yi;
			res.freq = coeff_angle(est_c_re, est_c_im);
			res.sat = sat;
			expected_freqs.push_back(res);
		end
	endtask

	// driver: hold a request until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				predict_frequency(s_tdata[15:0], s_tdata[31:16], s_tuser);
			if (!s_tvalid || s_tready) begin
				if (pending_samples.size() > 0 &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					sample_t it;
					it = pending_samples.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {it.im, it.re};
					s_tuser <= it.first;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: stall at random, compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
			if (m_tvalid && m_tready) begin
				if (expected_freqs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: freq %0d sat %0b", m_tdata, m_tuser);
				end else begin
					freq_result_t ex;
					ex = expected_freqs.pop_front();
					if (m_tdata !== {1'b0, ex.freq} || m_tuser !== ex.sat) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: freq exp %0d got %0d, sat exp %0b got %0b",
								ex.freq, m_tdata, ex.sat, m_tuser);
					end
				end
			end
		end
	end

	task automatic push_sample(input int re, input int im, input bit first);
		sample_t it;
		it.re = 16'(re);
		it.im = 16'(im);
		it.first = first;
		pending_samples.push_back(it);
	endtask

	function automatic int rand_component();
		int pick;
		pick = $urandom_range(9);
		if (pick < 2) begin
			case ($urandom_range(4))
				0: return -32768;
				1: return 32767;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		if (pick < 6)
			return $signed($urandom_range(511)) - 256;
		return $signed(16'($urandom()));
	endfunction

	// well-formed signals: mostly rotating phasors, some raw noise and stray samples
	task automatic push_random_signals(input int count);
		int n, len;
		real w, amp, ph;
		n = 0;
		while (n < count) begin
			len = $urandom_range(20, 3);
			if ($urandom_range(9) < 6) begin
				w = ($urandom_range(2000) / 1000.0 - 1.0) * 3.14159265;
				amp = $urandom_range(32000, 50);
				ph = $urandom_range(6283) / 1000.0;
				for (int k = 0; k < len; k++) begin
					push_sample(int'(amp * $cos(ph + w * k)) + $signed($urandom_range(8)) - 4,
						int'(amp * $sin(ph + w * k)) + $signed($urandom_range(8)) - 4,
						k == 0);
				end
			end else begin
				for (int k = 0; k < len; k++)
					push_sample(rand_component(), rand_component(),
						k == 0 || $urandom_range(9) == 0);
			end
			n += len;
		end
	endtask

	task automatic wait_drained();
		while (pending_samples.size() > 0 || s_tvalid || expected_freqs.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [rif_pkg::FF_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		est_alpha = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [rif_pkg::FF_W-1:0] alphas[NUM_PHASES];
		alphas = '{17'd65536, 17'd1, 17'd0, 17'd131071, 17'd32768, 17'd64880, 17'd0};
		alphas[NUM_PHASES-1] = 17'($urandom_range(65536, 1));
		mismatches = 0;
		calm = 1'b0;
		est_c_re = 0;
		est_c_im = 0;
		est_gain = GAIN_ONE;
		est_x_re = 0;
		est_x_im = 0;
		est_phase = 0;
		est_alpha = 65536;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray sample before any start, extremes and the special angles
		push_sample(1000, -2000, 1'b0);
		push_sample(32767, -32768, 1'b0);
		push_sample(-32768, 32767, 1'b0);
		push_sample(0, 0, 1'b1);
		push_sample(0, 0, 1'b0);
		push_sample(0, 0, 1'b0);
		push_sample(0, 1000, 1'b1);
		push_sample(0, 0, 1'b0);
		push_sample(5, 5, 1'b0);
		push_sample(-20000, 5000, 1'b1);
		push_sample(0, 0, 1'b0);
		push_sample(-32768, -32768, 1'b0);
		push_sample(-32768, -32768, 1'b0);
		push_sample(32767, 32767, 1'b0);
		push_sample(-32768, 32767, 1'b0);
		push_sample(1, -1, 1'b0);
		push_sample(32767, 0, 1'b1);
		push_sample(32767, 0, 1'b0);
		push_sample(-32768, 0, 1'b0);
		push_sample(-1, -1, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_alpha(alphas[p]);
			calm = (p == 1);
			if (p == 2) begin
				// zero alpha with a zero held sample drives the gain to its limit
				push_sample(300, 400, 1'b1);
				push_sample(0, 0, 1'b0);
				push_sample(0, 0, 1'b0);
			end
			push_random_signals(120);
		end
		wait_drained();
		calm = 1'b0;

		if (mismatches == 0 && expected_freqs.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// guard against a hang
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: rls_instantaneous_frequency_core.f
+incdir+hw/rtl
hw/rtl/rif_pkg.sv
hw/rtl/rif_front.sv
hw/rtl/rif_queue.sv
hw/rtl/rif_update.sv
hw/rtl/rif_cordic.sv
hw/rtl/rls_instantaneous_frequency_core.sv
tb/rls_instantaneous_frequency_core_tb.sv
